// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the LED pattern sequencer.
// Depends on nothing; every other file of the block but lps_ram refers to it by scoped names.
package lps_pkg;

  // Default table sizes.
  localparam int ENTRIES_DEF   = 8;
  localparam int MAX_STEPS_DEF = 8;

  // Reset value of the gap register.
  localparam logic [15:0] GAP_RESET = 16'd1000;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 1'd1;

  // Request action codes.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_HEADER = 2'd1;
  localparam logic [1:0] ACT_STEP   = 2'd2;

  // Pattern state as reported in the status field.
  typedef enum logic [1:0] {
    ST_AWAIT = 2'd0,
    ST_BUSY  = 2'd1,
    ST_DONE  = 2'd2
  } arch_state_t;

  // Sequencer state of the core.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_SCAN,
    SQ_SHOW,
    SQ_RELOAD,
    SQ_RESULT
  } seq_state_t;

  // One input request.
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  level;
    logic [2:0]  entry_index;
    logic [2:0]  step_index;
    logic [2:0]  color;
    logic [3:0]  length;
    logic [15:0] interval;
    logic [3:0]  mode;
  } item_t;

  // One result.
  typedef struct packed {
    logic [1:0] status;
    logic       done_flag;
    logic       led_enable;
    logic [2:0] led_color;
    logic [3:0] led_mode;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [3:0]  entries_in_use;
    logic [15:0] gap_ticks;
  } cfg_t;

  // Word of the entry header memory.
  typedef struct packed {
    logic [3:0] level;
    logic [2:0] color;
    logic [3:0] length;
  } entry_word_t;

  // Word of the step memory.
  typedef struct packed {
    logic [15:0] interval;
    logic [3:0]  mode;
  } step_word_t;

endpackage

// ===== sv/lps_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the LED pattern sequencer: request, result and configuration.
// Depends on lps_pkg for the configuration port widths.
interface lps_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  level;
  logic [2:0]  entry_index;
  logic [2:0]  step_index;
  logic [2:0]  color;
  logic [3:0]  length;
  logic [15:0] interval;
  logic [3:0]  mode;

  modport source (output valid, action, level, entry_index, step_index, color, length,
                  interval, mode, input ready);
  modport sink (input valid, action, level, entry_index, step_index, color, length,
                interval, mode, output ready);
endinterface

interface lps_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       done_flag;
  logic       led_enable;
  logic [2:0] led_color;
  logic [3:0] led_mode;

  modport source (output valid, status, done_flag, led_enable, led_color, led_mode,
                  input ready);
  modport sink (input valid, status, done_flag, led_enable, led_color, led_mode,
                output ready);
endinterface

interface lps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lps_pkg::CFG_IDX_W-1:0]  index;
  logic [lps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/led_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// LED pattern sequencer: configuration registers, result register and core.
// Depends on lps_pkg, lps_if and lps_core.
//
// Usage: load the pattern tables with header requests (action 1) and step
// requests (action 2), set entries_in_use and gap_ticks over the cfg channel,
// then send tick requests (action 0) carrying the sensor level. Every request
// gives exactly one result on the result channel with the pattern status,
// the done flag and the LED register.
// A write, or a tick that only counts the timer down, goes from the decode
// state to the result state. A tick that shows a step goes from decode to the
// show state, and on through the reload state when it reloads the timer for the
// next step. A tick in await scans the entry table one entry per cycle in a shared
// compare unit; a miss then goes to the result state, a match through reload.
// One request is in the core at a time; the item channel is ready again the
// cycle after the core hands its result to the output register, so no new
// request is taken before the result of the last one has been handed over.
// Reset returns the pattern to await with an expired timer and the LED off;
// the tables are not cleared and hold nothing defined until written.
// When the receiver stalls, the result waits in the output register, the core
// can take and finish one more request, then holds it until space frees up.
// The cfg channel is always ready and must be written only while idle.
module led_pattern_sequencer #(
  parameter int ENTRIES   = lps_pkg::ENTRIES_DEF,
  parameter int MAX_STEPS = lps_pkg::MAX_STEPS_DEF
) (
  input logic           clk,
  input logic           rst,
  lps_item_if.sink      item,
  lps_result_if.source  result,
  lps_cfg_if.sink       cfg
);

  lps_pkg::cfg_t    cfg_regs;
  lps_pkg::item_t   item_d;
  lps_pkg::result_t core_res;
  lps_pkg::result_t out_data;
  logic             out_valid;
  logic             core_ready;
  logic             core_res_valid;
  logic             core_res_ready;
  logic             res_take;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.entries_in_use <= '0;
      cfg_regs.gap_ticks      <= lps_pkg::GAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lps_pkg::REG_ENTRIES_IN_USE: cfg_regs.entries_in_use <= cfg.data[3:0];
        lps_pkg::REG_GAP_TICKS:      cfg_regs.gap_ticks      <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Request payload gathered into one word.
  assign item_d.action      = item.action;
  assign item_d.level       = item.level;
  assign item_d.entry_index = item.entry_index;
  assign item_d.step_index  = item.step_index;
  assign item_d.color       = item.color;
  assign item_d.length      = item.length;
  assign item_d.interval    = item.interval;
  assign item_d.mode        = item.mode;

  assign item.ready = core_ready;

  lps_core #(.ENTRIES(ENTRIES), .MAX_STEPS(MAX_STEPS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .start     (item.valid),
    .item      (item_d),
    .ready     (core_ready),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // Output register between the core and the result channel.
  assign core_res_ready = !out_valid || result.ready;
  assign res_take       = core_res_valid && core_res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= core_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_data.status;
  assign result.done_flag  = out_data.done_flag;
  assign result.led_enable = out_data.led_enable;
  assign result.led_color  = out_data.led_color;
  assign result.led_mode   = out_data.led_mode;

`ifndef SYNTHESIS
  // The core takes one request at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item channel ready right after a request was accepted");

  // A core with a finished result never takes a new request.
  a_hold_when_done: assert property (@(posedge clk) disable iff (rst)
    core_res_valid |-> !core_ready)
    else $error("core ready while its result is still pending");

  // The result register shows what the core handed over.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_take |=> (result.valid && result.done_flag == $past(core_res.done_flag)
                  && result.status == $past(core_res.status)))
    else $error("result register does not match the handed-over result");

  // Completion and a failed search are both reported with the LED off.
  a_done_led_off: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.done_flag) |-> !result.led_enable)
    else $error("done flag reported with the LED on");
`endif

endmodule

// ===== sv/lps_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lps_core.sv =====
`timescale 1ns / 1ps
// Sequencer core: pattern tables, timer, level search and LED state.
// Depends on lps_pkg and lps_ram.
module lps_core #(
  parameter int ENTRIES   = lps_pkg::ENTRIES_DEF,
  parameter int MAX_STEPS = lps_pkg::MAX_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lps_pkg::cfg_t    cfg,
  input  logic             start,
  input  lps_pkg::item_t   item,
  output logic             ready,
  output logic             res_valid,
  input  logic             res_ready,
  output lps_pkg::result_t res
);

  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int DEPTH = ENTRIES * MAX_STEPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(MAX_STEPS + 1);
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int ENT_W  = $bits(lps_pkg::entry_word_t);
  localparam int STEP_W = $bits(lps_pkg::step_word_t);

  // Flat step memory address of a step within an entry.
  function automatic logic [AW-1:0] step_addr(input logic [EW-1:0] e,
                                               input logic [SW-1:0] p);
    step_addr = AW'(AW'(e) * AW'(MAX_STEPS)) + AW'(p);
  endfunction

  lps_pkg::seq_state_t  state, state_next;
  lps_pkg::arch_state_t arch, arch_next;
  lps_pkg::item_t       item_q, item_q_next;
  logic [15:0]          timer, timer_next;
  logic [EW-1:0]        active, active_next;
  logic [PW-1:0]        pos, pos_next;
  logic [EW-1:0]        scan_idx, scan_idx_next;
  logic                 flag, flag_next;
  logic                 led_on, led_on_next;
  logic [2:0]           led_col, led_col_next;
  logic [3:0]           led_md, led_md_next;

  logic                 ent_we, step_we;
  logic [EW-1:0]        ent_waddr, ent_raddr;
  logic [AW-1:0]        step_waddr, step_raddr;
  logic [ENT_W-1:0]     ent_rdata;
  logic [STEP_W-1:0]    step_rdata;
  lps_pkg::entry_word_t ent_word;
  lps_pkg::step_word_t  step_word;

  logic [LW-1:0]        lim;
  logic [15:0]          timer_dec;
  logic [PW-1:0]        p_next, len_eff;
  logic                 ent_ok, step_ok;

  // Pattern table memories.
  lps_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ENT_W'({item_q.level, item_q.color, item_q.length})),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  lps_ram #(.WIDTH(STEP_W), .DEPTH(DEPTH)) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr),
    .wdata (STEP_W'({item_q.interval, item_q.mode})),
    .raddr (step_raddr),
    .rdata (step_rdata)
  );

  assign ent_word  = lps_pkg::entry_word_t'(ent_rdata);
  assign step_word = lps_pkg::step_word_t'(step_rdata);

  // Write guards and addresses of table writes.
  assign ent_ok     = 32'(item_q.entry_index) < ENTRIES;
  assign step_ok    = ent_ok && (32'(item_q.step_index) < MAX_STEPS);
  assign ent_waddr  = EW'(item_q.entry_index);
  assign step_waddr = step_addr(EW'(item_q.entry_index), SW'(item_q.step_index));

  // Search bound, timer decrement and step bound.
  assign lim       = (32'(cfg.entries_in_use) > ENTRIES) ? LW'(ENTRIES)
                                                          : LW'(cfg.entries_in_use);
  assign timer_dec = (timer != 16'd0) ? timer - 16'd1 : timer;
  assign p_next    = pos + PW'(1);
  assign len_eff   = (32'(ent_word.length) > MAX_STEPS) ? PW'(MAX_STEPS)
                                                         : PW'(ent_word.length);

  // Read addresses: the scan walks the entry table; the step table follows the pattern.
  always_comb begin
    ent_raddr  = (arch == lps_pkg::ST_BUSY) ? active : '0;
    step_raddr = step_addr(active, SW'(pos));
    if (state == lps_pkg::SQ_SCAN) begin
      ent_raddr  = scan_idx + EW'(1);
      step_raddr = step_addr(scan_idx, '0);
    end else if (state == lps_pkg::SQ_SHOW) begin
      step_raddr = step_addr(active, SW'(p_next));
    end
  end

  // Sequencer next state and datapath control.
  always_comb begin
    state_next    = state;
    arch_next     = arch;
    item_q_next   = item_q;
    timer_next    = timer;
    active_next   = active;
    pos_next      = pos;
    scan_idx_next = scan_idx;
    flag_next     = flag;
    led_on_next   = led_on;
    led_col_next  = led_col;
    led_md_next   = led_md;
    ent_we        = 1'b0;
    step_we       = 1'b0;
    ready         = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      lps_pkg::SQ_IDLE: begin
        ready = 1'b1;
        if (start) begin
          item_q_next = item;
          flag_next   = 1'b0;
          state_next  = lps_pkg::SQ_DECODE;
        end
      end

      lps_pkg::SQ_DECODE: begin
        state_next = lps_pkg::SQ_RESULT;
        unique case (item_q.action)
          lps_pkg::ACT_TICK: begin
            timer_next = timer_dec;
            if (timer_dec == 16'd0) begin
              unique case (arch)
                lps_pkg::ST_AWAIT: begin
                  if (lim == '0) begin
                    arch_next = lps_pkg::ST_DONE;
                    flag_next = 1'b1;
                  end else begin
                    scan_idx_next = '0;
                    state_next    = lps_pkg::SQ_SCAN;
                  end
                end
                lps_pkg::ST_BUSY: begin
                  state_next = lps_pkg::SQ_SHOW;
                end
                lps_pkg::ST_DONE: begin
                  led_on_next = 1'b0;
                  arch_next   = lps_pkg::ST_AWAIT;
                  flag_next   = 1'b1;
                end
                default: begin
                  arch_next = lps_pkg::ST_AWAIT;
                end
              endcase
            end
          end
          lps_pkg::ACT_HEADER: begin
            ent_we = ent_ok;
          end
          lps_pkg::ACT_STEP: begin
            step_we = step_ok;
          end
          default: begin
          end
        endcase
      end

      // One entry compared per cycle; the first match wins.
      lps_pkg::SQ_SCAN: begin
        if (ent_word.level == item_q.level) begin
          active_next = scan_idx;
          pos_next    = '0;
          arch_next   = lps_pkg::ST_BUSY;
          state_next  = lps_pkg::SQ_RELOAD;
        end else if ((LW'(scan_idx) + LW'(1)) < lim) begin
          scan_idx_next = scan_idx + EW'(1);
        end else begin
          arch_next  = lps_pkg::ST_DONE;
          flag_next  = 1'b1;
          state_next = lps_pkg::SQ_RESULT;
        end
      end

      // Show the current step and move to the next one or to the gap.
      lps_pkg::SQ_SHOW: begin
        led_on_next  = 1'b1;
        led_col_next = ent_word.color;
        led_md_next  = step_word.mode;
        pos_next     = p_next;
        if (p_next < len_eff) begin
          state_next = lps_pkg::SQ_RELOAD;
        end else begin
          arch_next  = lps_pkg::ST_DONE;
          timer_next = cfg.gap_ticks;
          state_next = lps_pkg::SQ_RESULT;
        end
      end

      lps_pkg::SQ_RELOAD: begin
        timer_next = step_word.interval;
        state_next = lps_pkg::SQ_RESULT;
      end

      lps_pkg::SQ_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = lps_pkg::SQ_IDLE;
        end
      end

      default: begin
        state_next = lps_pkg::SQ_IDLE;
      end
    endcase
  end

  // Control and LED registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lps_pkg::SQ_IDLE;
      arch    <= lps_pkg::ST_AWAIT;
      timer   <= '0;
      active  <= '0;
      pos     <= '0;
      flag    <= 1'b0;
      led_on  <= 1'b0;
      led_col <= '0;
      led_md  <= '0;
    end else begin
      state   <= state_next;
      arch    <= arch_next;
      timer   <= timer_next;
      active  <= active_next;
      pos     <= pos_next;
      flag    <= flag_next;
      led_on  <= led_on_next;
      led_col <= led_col_next;
      led_md  <= led_md_next;
    end
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    item_q   <= item_q_next;
    scan_idx <= scan_idx_next;
  end

  assign res.status     = arch;
  assign res.done_flag  = flag;
  assign res.led_enable = led_on;
  assign res.led_color  = led_col;
  assign res.led_mode   = led_md;

endmodule
